// ===== sv/dpdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpdc_pkg
// Shared types and constants for the dual PD drive controller.
// ----------------------------------------------------------------------------
package dpdc_pkg;

	localparam int unsigned COUNT_W = 16;  // encoder counts, targets
	localparam int unsigned GAIN_W  = 16;  // unsigned Q0.16 gains
	localparam int unsigned ERR_W   = 18;  // angle / distance error
	localparam int unsigned DRIVE_W = 16;  // Q1.15 drive and correction
	localparam int unsigned TICK_W  = 6;   // settle tick counter
	localparam int unsigned ADDR_W  = 5;   // byte address of six 32-bit registers
	localparam int unsigned DATA_W  = 32;

	// reset values of the gain registers
	localparam logic [GAIN_W-1:0] ANGLE_P_RST = 16'd262;
	localparam logic [GAIN_W-1:0] ANGLE_D_RST = 16'd1311;
	localparam logic [GAIN_W-1:0] DIST_P_RST  = 16'd275;
	localparam logic [GAIN_W-1:0] DIST_D_RST  = 16'd1311;

	typedef enum logic [2:0] {
		REG_TARGET_ANGLE    = 3'd0,
		REG_TARGET_DISTANCE = 3'd1,
		REG_ANGLE_P_GAIN    = 3'd2,
		REG_ANGLE_D_GAIN    = 3'd3,
		REG_DIST_P_GAIN     = 3'd4,
		REG_DIST_D_GAIN     = 3'd5
	} reg_idx_t;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] kd;
	} pd_gains_t;

endpackage
`default_nettype wire

// ===== sv/dual_pd_drive_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pd_drive_controller
// Angle and distance PD loops for a two-wheeled drive, one beat per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (item_valid/item_ready) carries op, left_count, right_count.
//    op = tick runs both PD loops; op = clear zeroes the previous errors, the
//    settle tick counter and both settled flags, and returns a zero result.
//  - Output channel (result_valid/result_ready) returns one beat per input
//    beat: left_drive, right_drive (Q1.15) and goal_reached.
//  - A beat is captured in the input register; the whole computation (four
//    multiplies, sums, clamps, settle check) then runs combinationally into
//    the result register. Throughput: one beat per cycle unless the receiver
//    stalls; the single compute stage sets it.
//  - A stalled receiver holds the result register; the input register then
//    holds too, and item_ready drops only once both are full.
//  - Gains and targets sit on an APB-style port at byte address 4*index;
//    writes take effect on the next tick. Reads return the register value.
//  - Reset (arst_n low) empties the pipeline, restores default gains, zero
//    targets and clears all controller state.
// ----------------------------------------------------------------------------
module dual_pd_drive_controller #(
	parameter int unsigned SETTLE_PERIOD    = 51,
	parameter int unsigned SETTLE_BAND      = 28,
	parameter int unsigned CORRECTION_LIMIT = 13107
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic                                  op,
	input  logic signed [dpdc_pkg::COUNT_W-1:0]   left_count,
	input  logic signed [dpdc_pkg::COUNT_W-1:0]   right_count,
	// result channel
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [dpdc_pkg::DRIVE_W-1:0]   left_drive,
	output logic signed [dpdc_pkg::DRIVE_W-1:0]   right_drive,
	output logic                                  goal_reached,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dpdc_pkg::ADDR_W-1:0]           paddr,
	input  logic [dpdc_pkg::DATA_W-1:0]           pwdata,
	output logic [dpdc_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);
	import dpdc_pkg::*;

	localparam logic [TICK_W-1:0]       PERIOD = TICK_W'(SETTLE_PERIOD);
	localparam logic signed [ERR_W-1:0] BAND   = ERR_W'(SETTLE_BAND);

	// ---------------- configuration registers ----------------
	logic signed [COUNT_W-1:0] target_angle_q;
	logic signed [COUNT_W-1:0] target_dist_q;
	pd_gains_t                 angle_gains_q;
	pd_gains_t                 dist_gains_q;
	reg_idx_t                  reg_idx;
	logic                      cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q   <= '0;
			target_dist_q    <= '0;
			angle_gains_q.kp <= ANGLE_P_RST;
			angle_gains_q.kd <= ANGLE_D_RST;
			dist_gains_q.kp  <= DIST_P_RST;
			dist_gains_q.kd  <= DIST_D_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TARGET_ANGLE:    target_angle_q   <= $signed(pwdata[COUNT_W-1:0]);
				REG_TARGET_DISTANCE: target_dist_q    <= $signed(pwdata[COUNT_W-1:0]);
				REG_ANGLE_P_GAIN:    angle_gains_q.kp <= pwdata[GAIN_W-1:0];
				REG_ANGLE_D_GAIN:    angle_gains_q.kd <= pwdata[GAIN_W-1:0];
				REG_DIST_P_GAIN:     dist_gains_q.kp  <= pwdata[GAIN_W-1:0];
				REG_DIST_D_GAIN:     dist_gains_q.kd  <= pwdata[GAIN_W-1:0];
				default: ;  // unmapped: ignored
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET_ANGLE:    prdata = DATA_W'(target_angle_q);
			REG_TARGET_DISTANCE: prdata = DATA_W'(target_dist_q);
			REG_ANGLE_P_GAIN:    prdata = DATA_W'(angle_gains_q.kp);
			REG_ANGLE_D_GAIN:    prdata = DATA_W'(angle_gains_q.kd);
			REG_DIST_P_GAIN:     prdata = DATA_W'(dist_gains_q.kp);
			REG_DIST_D_GAIN:     prdata = DATA_W'(dist_gains_q.kd);
			default:             prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic                      valid_s1;
	logic                      op_s1;
	logic signed [COUNT_W-1:0] left_s1;
	logic signed [COUNT_W-1:0] right_s1;
	logic                      advance;

	// the compute stage moves on whenever the result register is free or drains
	assign advance    = valid_s1 & (~result_valid | result_ready);
	assign item_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid & item_ready) begin
			op_s1    <= op;
			left_s1  <= left_count;
			right_s1 <= right_count;
		end
	end

	// ---------------- error terms ----------------
	logic signed [ERR_W-1:0]   angle_err;
	logic signed [COUNT_W:0]   count_sum;
	logic signed [COUNT_W:0]   count_sum_adj;
	logic signed [COUNT_W:0]   count_avg;
	logic signed [ERR_W-1:0]   dist_err;

	assign angle_err = ERR_W'(target_angle_q) + ERR_W'(left_s1) - ERR_W'(right_s1);

	// average truncates toward zero: bias negative sums by one before the shift
	assign count_sum     = (COUNT_W+1)'(left_s1) + (COUNT_W+1)'(right_s1);
	assign count_sum_adj = count_sum + $signed({{COUNT_W{1'b0}}, count_sum[COUNT_W]});
	assign count_avg     = count_sum_adj >>> 1;
	assign dist_err      = ERR_W'(target_dist_q) - ERR_W'(count_avg);

	// ---------------- state ----------------
	logic signed [ERR_W-1:0] prev_angle_err_q;
	logic signed [ERR_W-1:0] prev_dist_err_q;
	logic [TICK_W-1:0]       tick_cnt_q;
	logic                    angle_settled_q;
	logic                    dist_settled_q;

	logic [TICK_W-1:0]       tick_next;
	logic                    settle_chk;
	logic                    angle_in_band;
	logic                    dist_in_band;
	logic                    angle_settled_nx;
	logic                    dist_settled_nx;

	assign tick_next     = tick_cnt_q + TICK_W'(1);
	assign settle_chk    = (tick_next >= PERIOD);
	assign angle_in_band = (angle_err <= BAND) && (angle_err >= -BAND);
	assign dist_in_band  = (dist_err <= BAND) && (dist_err >= -BAND);
	assign angle_settled_nx = angle_settled_q | (settle_chk & angle_in_band);
	assign dist_settled_nx  = dist_settled_q | (settle_chk & dist_in_band);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_err_q <= '0;
			prev_dist_err_q  <= '0;
			tick_cnt_q       <= '0;
			angle_settled_q  <= 1'b0;
			dist_settled_q   <= 1'b0;
		end else if (advance) begin
			if (op_s1 == OP_CLEAR) begin
				prev_angle_err_q <= '0;
				prev_dist_err_q  <= '0;
				tick_cnt_q       <= '0;
				angle_settled_q  <= 1'b0;
				dist_settled_q   <= 1'b0;
			end else begin
				prev_angle_err_q <= angle_err;
				prev_dist_err_q  <= dist_err;
				tick_cnt_q       <= settle_chk ? '0 : tick_next;
				angle_settled_q  <= angle_settled_nx;
				dist_settled_q   <= dist_settled_nx;
			end
		end
	end

	// ---------------- PD terms ----------------
	logic signed [DRIVE_W-1:0] angle_corr;
	logic signed [DRIVE_W-1:0] dist_corr;

	dpdc_pd_term #(
		.CORRECTION_LIMIT(CORRECTION_LIMIT)
	) u_angle_pd (
		.gains (angle_gains_q),
		.err   (angle_err),
		.prev  (prev_angle_err_q),
		.corr  (angle_corr)
	);

	dpdc_pd_term #(
		.CORRECTION_LIMIT(CORRECTION_LIMIT)
	) u_dist_pd (
		.gains (dist_gains_q),
		.err   (dist_err),
		.prev  (prev_dist_err_q),
		.corr  (dist_corr)
	);

	// ---------------- result register ----------------
	logic                      result_valid_q;
	logic signed [DRIVE_W-1:0] left_drive_q;
	logic signed [DRIVE_W-1:0] right_drive_q;
	logic                      goal_reached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (op_s1 == OP_CLEAR) begin
				left_drive_q   <= '0;
				right_drive_q  <= '0;
				goal_reached_q <= 1'b0;
			end else begin
				// each correction is within the limit, so neither sum wraps
				left_drive_q   <= dist_corr - angle_corr;
				right_drive_q  <= dist_corr + angle_corr;
				goal_reached_q <= angle_settled_nx & dist_settled_nx;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign left_drive   = left_drive_q;
	assign right_drive  = right_drive_q;
	assign goal_reached = goal_reached_q;

	// ---------------- assertions ----------------
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(2 * CORRECTION_LIMIT);

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (left_drive <= DRIVE_MAX) && (left_drive >= -DRIVE_MAX) &&
		                 (right_drive <= DRIVE_MAX) && (right_drive >= -DRIVE_MAX))
		else $error("drive outside clamp range");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_CLEAR) |=>
		(left_drive == '0) && (right_drive == '0) && !goal_reached &&
		(tick_cnt_q == '0) && !angle_settled_q && !dist_settled_q)
		else $error("clear beat left state or result non-zero");

	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_cnt_q < PERIOD)
		else $error("settle tick counter passed its period");

	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && !result_ready) |-> !item_ready)
		else $error("input taken while both stages are stalled");

endmodule
`default_nettype wire

// ===== sv/dpdc_pd_term.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpdc_pd_term
// One PD correction: kp*e + kd*(e - prev), halved (floor) into Q1.15, clamped.
// ----------------------------------------------------------------------------
module dpdc_pd_term #(
	parameter int unsigned CORRECTION_LIMIT = 13107
) (
	input  dpdc_pkg::pd_gains_t                   gains,
	input  logic signed [dpdc_pkg::ERR_W-1:0]     err,
	input  logic signed [dpdc_pkg::ERR_W-1:0]     prev,
	output logic signed [dpdc_pkg::DRIVE_W-1:0]   corr
);
	import dpdc_pkg::*;

	localparam int unsigned PP_W  = GAIN_W + 1 + ERR_W;      // 17 x 18
	localparam int unsigned DP_W  = GAIN_W + 1 + ERR_W + 1;  // 17 x 19
	localparam int unsigned SUM_W = DP_W + 1;
	localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(CORRECTION_LIMIT);
	localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

	logic signed [ERR_W:0]   diff;
	logic signed [PP_W-1:0]  p_prod;
	logic signed [DP_W-1:0]  d_prod;
	logic signed [SUM_W-1:0] pd_sum;
	logic signed [SUM_W-1:0] pd_half;

	assign diff    = (ERR_W+1)'(err) - (ERR_W+1)'(prev);
	assign p_prod  = $signed({1'b0, gains.kp}) * err;
	assign d_prod  = $signed({1'b0, gains.kd}) * diff;
	assign pd_sum  = SUM_W'(p_prod) + SUM_W'(d_prod);
	assign pd_half = pd_sum >>> 1;  // rounds toward minus infinity

	always_comb begin
		if (pd_half > LIM_POS) begin
			corr = DRIVE_W'(LIM_POS);
		end else if (pd_half < LIM_NEG) begin
			corr = DRIVE_W'(LIM_NEG);
		end else begin
			corr = DRIVE_W'(pd_half);
		end
	end

endmodule
`default_nettype wire

// ===== bench/dpdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_checker
// Watches the tick, result and register channels of the dual PD drive
// controller. It keeps its own copy of the registers and loop state, predicts
// each result beat and compares it with what comes out. It also checks reads.
// ----------------------------------------------------------------------------
module dpdc_checker #(
	parameter int unsigned SETTLE_PERIOD    = 51,
	parameter int unsigned SETTLE_BAND      = 28,
	parameter int unsigned CORRECTION_LIMIT = 13107
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_ready,
	input  logic                                op,
	input  logic signed [dpdc_pkg::COUNT_W-1:0] left_count,
	input  logic signed [dpdc_pkg::COUNT_W-1:0] right_count,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic signed [dpdc_pkg::DRIVE_W-1:0] left_drive,
	input  logic signed [dpdc_pkg::DRIVE_W-1:0] right_drive,
	input  logic                                goal_reached,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [dpdc_pkg::ADDR_W-1:0]         paddr,
	input  logic [dpdc_pkg::DATA_W-1:0]         pwdata,
	input  logic [dpdc_pkg::DATA_W-1:0]         prdata,
	output int                                  fail_count,
	output int                                  outstanding
);
	import dpdc_pkg::*;

	// signed copies, so band and clamp compares stay signed
	localparam int PERIOD = SETTLE_PERIOD;
	localparam int BAND   = SETTLE_BAND;
	localparam int LIMIT  = CORRECTION_LIMIT;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left_cmd;
		logic signed [DRIVE_W-1:0] right_cmd;
		logic                      goal;
	} drive_beat_t;

	// register mirror
	logic signed [COUNT_W-1:0] aim_angle;
	logic signed [COUNT_W-1:0] aim_dist;
	logic [GAIN_W-1:0]         ang_kp, ang_kd, dist_kp, dist_kd;

	// loop state
	int          last_ang_err;
	int          last_dist_err;
	int unsigned ticks;
	bit          ang_done;
	bit          dist_done;

	drive_beat_t due_q[$];
	int          beat_no;

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch at result beat %0d: got %0d, expected %0d",
			$time, what, beat_no, got, want);
		fail_count++;
	endtask

	function automatic int pd_correction(input logic [GAIN_W-1:0] kp, kd, input int err, prev);
		longint s, kpl, kdl;
		kpl = kp;
		kdl = kd;
		s = kpl * err + kdl * (longint'(err) - prev);
		s = s >>> 1;  // Q16 -> Q15, floor
		if (s > LIMIT)
			s = LIMIT;
		else if (s < -LIMIT)
			s = -LIMIT;
		return int'(s);
	endfunction

	function automatic drive_beat_t advance_loops(input logic o,
			input logic signed [COUNT_W-1:0] lc, rc);
		drive_beat_t res;
		int l, r, ae, de, ac, dc;
		res = '0;
		if (o == OP_CLEAR) begin
			last_ang_err = 0;
			last_dist_err = 0;
			ticks = 0;
			ang_done = 0;
			dist_done = 0;
			return res;
		end
		l = lc;
		r = rc;
		ae = aim_angle + l - r;
		de = aim_dist - (l + r) / 2;  // truncates toward zero
		ac = pd_correction(ang_kp, ang_kd, ae, last_ang_err);
		dc = pd_correction(dist_kp, dist_kd, de, last_dist_err);
		last_ang_err = ae;
		last_dist_err = de;
		ticks = (ticks + 1) % 64;
		if (ticks >= PERIOD) begin
			if (ae <= BAND && ae >= -BAND)
				ang_done = 1;
			if (de <= BAND && de >= -BAND)
				dist_done = 1;
			ticks = 0;
		end
		res.left_cmd = DRIVE_W'(dc - ac);
		res.right_cmd = DRIVE_W'(dc + ac);
		res.goal = ang_done && dist_done;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [2:0]        idx;
		logic [GAIN_W-1:0] want_reg;
		bit                mapped;
		drive_beat_t       want;
		if (!arst_n) begin
			aim_angle = '0;
			aim_dist = '0;
			ang_kp = ANGLE_P_RST;
			ang_kd = ANGLE_D_RST;
			dist_kp = DIST_P_RST;
			dist_kd = DIST_D_RST;
			last_ang_err = 0;
			last_dist_err = 0;
			ticks = 0;
			ang_done = 0;
			dist_done = 0;
			due_q.delete();
			beat_no = 0;
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (due_q.size() == 0) begin
					flag_mismatch("spurious result", 1, 0);
				end else begin
					want = due_q.pop_front();
					if (left_drive !== want.left_cmd)
						flag_mismatch("left_drive", left_drive, want.left_cmd);
					if (right_drive !== want.right_cmd)
						flag_mismatch("right_drive", right_drive, want.right_cmd);
					if (goal_reached !== want.goal)
						flag_mismatch("goal_reached", goal_reached, want.goal);
				end
				beat_no++;
			end
			if (item_valid && item_ready)
				due_q.push_back(advance_loops(op, left_count, right_count));
			if (psel && penable && pready) begin
				idx = paddr[ADDR_W-1:2];
				mapped = 1;
				want_reg = '0;
				case (idx)
					REG_TARGET_ANGLE:    want_reg = aim_angle;
					REG_TARGET_DISTANCE: want_reg = aim_dist;
					REG_ANGLE_P_GAIN:    want_reg = ang_kp;
					REG_ANGLE_D_GAIN:    want_reg = ang_kd;
					REG_DIST_P_GAIN:     want_reg = dist_kp;
					REG_DIST_D_GAIN:     want_reg = dist_kd;
					default:             mapped = 0;
				endcase
				if (pwrite) begin
					case (idx)
						REG_TARGET_ANGLE:    aim_angle = pwdata[COUNT_W-1:0];
						REG_TARGET_DISTANCE: aim_dist = pwdata[COUNT_W-1:0];
						REG_ANGLE_P_GAIN:    ang_kp = pwdata[GAIN_W-1:0];
						REG_ANGLE_D_GAIN:    ang_kd = pwdata[GAIN_W-1:0];
						REG_DIST_P_GAIN:     dist_kp = pwdata[GAIN_W-1:0];
						REG_DIST_D_GAIN:     dist_kd = pwdata[GAIN_W-1:0];
						default:             ;  // unmapped, dropped
					endcase
				end else if (mapped && prdata[GAIN_W-1:0] !== want_reg) begin
					flag_mismatch("register read", prdata[GAIN_W-1:0], want_reg);
				end
			end
			outstanding = due_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives ticks, clears and register traffic into the dual PD drive controller
// and gives the verdict. Checking lives in dpdc_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
	import dpdc_pkg::*;

	localparam int unsigned SETTLE_PERIOD    = 51;
	localparam int unsigned SETTLE_BAND      = 28;
	localparam int unsigned CORRECTION_LIMIT = 13107;
	localparam int unsigned REG_COUNT        = 6;    // first unmapped index
	localparam int unsigned PHASES           = 8;
	localparam int unsigned PHASE_BEATS      = 116;

	// every block input starts at a known value
	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      item_valid   = 1'b0;
	logic                      op           = OP_TICK;
	logic signed [COUNT_W-1:0] left_count   = '0;
	logic signed [COUNT_W-1:0] right_count  = '0;
	logic                      result_ready = 1'b0;
	logic                      psel         = 1'b0;
	logic                      penable      = 1'b0;
	logic                      pwrite       = 1'b0;
	logic [ADDR_W-1:0]         paddr        = '0;
	logic [DATA_W-1:0]         pwdata       = '0;

	logic                      item_ready;
	logic                      result_valid;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic                      goal_reached;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	int                        fail_count;
	int                        outstanding;

	// idling odds in percent, changed per phase; both zero near the end
	int unsigned               gap_odds   = 0;
	int unsigned               stall_odds = 20;
	int unsigned               stall_left = 0;

	// targets of the current phase, used to aim ticks near the goal
	int                        tgt_angle = 0;
	int                        tgt_dist  = 0;

	dual_pd_drive_controller #(
		.SETTLE_PERIOD    (SETTLE_PERIOD),
		.SETTLE_BAND      (SETTLE_BAND),
		.CORRECTION_LIMIT (CORRECTION_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.left_count   (left_count),
		.right_count  (right_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.goal_reached (goal_reached),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	dpdc_checker #(
		.SETTLE_PERIOD    (SETTLE_PERIOD),
		.SETTLE_BAND      (SETTLE_BAND),
		.CORRECTION_LIMIT (CORRECTION_LIMIT)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.left_count   (left_count),
		.right_count  (right_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.goal_reached (goal_reached),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side back-pressure: now and then ready drops for a burst of
	// random length. With stall_odds at zero the receiver never stalls.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(1, 100) <= stall_odds) begin
			stall_left <= $urandom_range(0, 11);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// One beat on the tick channel. Called at a rising edge and returns at
	// the edge that accepts the beat, leaving valid high, so back-to-back
	// beats see a single assignment to valid per edge. A sender gap, when
	// drawn, drops valid first.
	task automatic push_beat(input logic o, input logic signed [COUNT_W-1:0] l, r);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(1, 100) <= gap_odds)
			gap = $urandom_range(1, 12);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= o;
		left_count <= l;
		right_count <= r;
		do @(posedge clk); while (!item_ready);
	endtask

	// Sender holds off until every predicted beat has come back, then lets
	// the two-stage pipe run dry before anything else happens. The count is
	// looked at on the falling edge, away from the checker's update.
	task automatic settle_down();
		item_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup phase, then access phase, then idle, so that back-to-back
	// accesses never assign psel twice in one step.
	task automatic reg_access(input logic wr, input int unsigned idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(idx << 2);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all();
		for (int unsigned i = 0; i < REG_COUNT; i++)
			reg_access(1'b0, i, '0);
	endtask

	// Writes all six registers, then reads them back through the checker.
	task automatic load_settings(input int ta, td, akp, akd, dkp, dkd);
		tgt_angle = ta;
		tgt_dist = td;
		reg_access(1'b1, REG_TARGET_ANGLE, DATA_W'(ta));
		reg_access(1'b1, REG_TARGET_DISTANCE, DATA_W'(td));
		reg_access(1'b1, REG_ANGLE_P_GAIN, DATA_W'(akp));
		reg_access(1'b1, REG_ANGLE_D_GAIN, DATA_W'(akd));
		reg_access(1'b1, REG_DIST_P_GAIN, DATA_W'(dkp));
		reg_access(1'b1, REG_DIST_D_GAIN, DATA_W'(dkd));
		read_all();
	endtask

	// gains: zero, full scale, small (mostly unclamped output) or anything
	function automatic int pick_gain();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			2, 3:    return $urandom_range(0, 511);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// targets: mostly moderate, so ticks can be aimed near them
	function automatic int pick_target();
		case ($urandom_range(0, 7))
			0:       return -32768;
			1:       return 32767;
			2:       return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 4000)) - 2000;
		endcase
	endfunction

	// Random tick traffic. Most beats are aimed so that both errors land
	// within +/-40 of zero, straddling the settle band, which lets the settle
	// check fire both ways and the goal flag come up. The rest are full range
	// noise and the odd clear, kept rare so the tick counter still reaches
	// its period between clears.
	task automatic random_beat();
		int          ae, de, s, d, l, r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 1) begin
			push_beat(OP_CLEAR, COUNT_W'($urandom), COUNT_W'($urandom));
			return;
		end
		if (pick < 16) begin
			push_beat(OP_TICK, COUNT_W'($urandom), COUNT_W'($urandom));
			return;
		end
		ae = int'($urandom_range(0, 80)) - 40;
		de = int'($urandom_range(0, 80)) - 40;
		d = ae - tgt_angle;           // wanted left - right
		s = 2 * (tgt_dist - de);      // wanted left + right
		l = (s + d) >>> 1;
		r = l - d;
		if (l < -32768 || l > 32767 || r < -32768 || r > 32767) begin
			// target out of reach of 16-bit counts: plain noise instead
			l = int'($urandom_range(0, 65535)) - 32768;
			r = int'($urandom_range(0, 65535)) - 32768;
		end
		push_beat(OP_TICK, COUNT_W'(l), COUNT_W'(r));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values read back, then ticks under the default gains:
		// zero counts, both count extremes, sum rounding toward zero for
		// negative odd sums, and a clear followed by a fresh tick.
		read_all();
		push_beat(OP_TICK, 16'sd0, 16'sd0);
		push_beat(OP_TICK, 16'sd32767, -16'sd32768);
		push_beat(OP_TICK, -16'sd32768, 16'sd32767);
		push_beat(OP_TICK, 16'sd32767, 16'sd32767);
		push_beat(OP_TICK, -16'sd32768, -16'sd32768);
		push_beat(OP_TICK, -16'sd1, 16'sd0);
		push_beat(OP_TICK, -16'sd3, 16'sd0);
		push_beat(OP_TICK, 16'sd3, 16'sd0);
		push_beat(OP_CLEAR, 16'sd12345, -16'sd4321);
		push_beat(OP_TICK, 16'sd100, -16'sd100);
		settle_down();

		// Writes to the two unmapped slots must leave the map alone.
		// Then full-scale gains with extreme targets: largest errors of
		// both signs, corrections pinned at the clamp.
		gap_odds <= 30;
		reg_access(1'b1, REG_COUNT, '1);
		reg_access(1'b1, REG_COUNT + 1, '1);
		load_settings(32767, -32768, 65535, 65535, 65535, 65535);
		push_beat(OP_TICK, 16'sd32767, -16'sd32768);
		push_beat(OP_TICK, -16'sd32768, 16'sd32767);
		push_beat(OP_TICK, 16'sd0, 16'sd0);
		push_beat(OP_TICK, 16'sd32767, 16'sd32767);
		push_beat(OP_TICK, -16'sd32768, -16'sd32768);
		push_beat(OP_CLEAR, -16'sd1, -16'sd1);
		settle_down();

		// Opposite extreme targets with zero gains: drives must be zero.
		load_settings(-32768, 32767, 0, 0, 0, 0);
		push_beat(OP_TICK, -16'sd32768, 16'sd32767);
		push_beat(OP_TICK, 16'sd32767, -16'sd32768);
		push_beat(OP_TICK, 16'sd5, -16'sd7);
		settle_down();

		// Random phases, each with fresh settings and its own idling mix;
		// the last phase runs with no idling at all.
		for (int unsigned p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				gap_odds <= 0;
				stall_odds <= 0;
			end else begin
				gap_odds <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
				stall_odds <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			end
			load_settings(pick_target(), pick_target(), pick_gain(), pick_gain(),
				pick_gain(), pick_gain());
			for (int unsigned n = 0; n < PHASE_BEATS; n++)
				random_beat();
			settle_down();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dpdc_pkg.sv
sv/dpdc_pd_term.sv
sv/dual_pd_drive_controller.sv
bench/dpdc_checker.sv
bench/tb.sv
